### design/kinematic_state_forward_integrator_core_macros.svh
// Assertion macros for the kinematic forward integrator.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef KINEMATIC_STATE_FORWARD_INTEGRATOR_CORE_MACROS_SVH
`define KINEMATIC_STATE_FORWARD_INTEGRATOR_CORE_MACROS_SVH

// same-cycle implication
`define KSFI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KSFI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ksfi_pkg.sv
// Shared constants and types for the kinematic forward integrator.
// No dependencies; used by ksfi_div and the top level.
`default_nettype none

package ksfi_pkg;

  localparam int MAX_STEPS = 256;
  localparam int STEPS_W   = $clog2(MAX_STEPS + 1);
  localparam int STEP_W    = 10;
  localparam logic [STEP_W-1:0] STEP_RESET = 10'd50;

  // divider: unsigned dividend width, divisor width, bits per cycle
  localparam int DIV_W   = 40;
  localparam int DEN_W   = 19;
  localparam int DIV_BPC = 4;
  localparam int DIV_ITERS = DIV_W / DIV_BPC;
  localparam int DIV_CNT_W = $clog2(DIV_ITERS);

  // divisors: the odd part of every rounding scale, and 2*pi in Q.16
  localparam logic [DEN_W-1:0] DEN_SCALE  = 19'd125;
  localparam logic [DEN_W-1:0] DEN_TWO_PI = 19'd411775;

  localparam int CORDIC_ITERS = 16;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  localparam logic signed [31:0] ATAN_Q28 [CORDIC_ITERS] = '{
    32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
    32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
    32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
    32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192
  };

  // request to the shared divider
  typedef struct packed {
    logic start;
    logic mod_sel;   // 1: divide by 2*pi, 0: divide by the scale
  } div_req_t;

endpackage

`default_nettype wire

### design/ksfi_div.sv
// Shared unsigned divider by a constant (scale or 2*pi), 4 quotient bits per cycle.
// Depends on ksfi_pkg.
`default_nettype none

module ksfi_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ksfi_pkg::div_req_t            req_i,
  input  wire logic [ksfi_pkg::DIV_W-1:0]    dividend_i,
  output logic                               done_o,
  output logic [ksfi_pkg::DIV_W-1:0]         quot_o,
  output logic [ksfi_pkg::DEN_W-1:0]         rem_o
);

  logic                               busy_q, done_q, sel_q;
  logic [ksfi_pkg::DIV_CNT_W-1:0]     cnt_q;
  logic [ksfi_pkg::DIV_W-1:0]         num_q, quot_q;
  logic [ksfi_pkg::DEN_W-1:0]         rem_q, rem_d;
  logic [ksfi_pkg::DIV_BPC-1:0]       qbits;
  logic [ksfi_pkg::DEN_W-1:0]         den;

  assign den = sel_q ? ksfi_pkg::DEN_TWO_PI : ksfi_pkg::DEN_SCALE;

  // four restoring steps per cycle, MSB first
  always_comb begin
    logic [ksfi_pkg::DEN_W:0] t;
    logic [ksfi_pkg::DEN_W-1:0] r;
    r = rem_q;
    qbits = '0;
    for (int j = 0; j < ksfi_pkg::DIV_BPC; j++) begin
      t = {r, num_q[ksfi_pkg::DIV_W-1-j]};
      if (t >= {1'b0, den}) begin
        t = t - {1'b0, den};
        qbits[ksfi_pkg::DIV_BPC-1-j] = 1'b1;
      end
      r = t[ksfi_pkg::DEN_W-1:0];
    end
    rem_d = r;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == ksfi_pkg::DIV_CNT_W'(ksfi_pkg::DIV_ITERS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q  <= dividend_i;
      rem_q  <= '0;
      quot_q <= '0;
      sel_q  <= req_i.mod_sel;
    end else if (busy_q) begin
      num_q  <= {num_q[ksfi_pkg::DIV_W-ksfi_pkg::DIV_BPC-1:0], {ksfi_pkg::DIV_BPC{1'b0}}};
      rem_q  <= rem_d;
      quot_q <= {quot_q[ksfi_pkg::DIV_W-ksfi_pkg::DIV_BPC-1:0], qbits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

### design/kinematic_state_forward_integrator_core.sv
// Top level of the kinematic forward integrator: sequencer, shared multiplier, CORDIC.
// Depends on ksfi_pkg, ksfi_div and the assertion macro header.
//
//  channel | direction | handshake                | payload
//  in      | in        | in_valid_i / in_ready_o  | start state and horizon_ms_i
//  out     | out       | out_valid_o / out_ready_i| end state and bad_horizon_o
//  cfg     | in        | cfg_valid_i / cfg_ready_o| cfg_step_ms_i
//
// An item runs a setup of two divisions, then one integration step per loop pass,
// up to 256 steps; a zero horizon goes straight to the output state.
// Each step uses the shared divider (4 bits a cycle, 5 divisions a step) and the CORDIC.
// Reset clears the sequencer and sets step_ms to 50.
// A new item is taken once the previous result sits in the output register;
// a stalled output holds the sequencer in its final state.
`default_nettype none
`include "kinematic_state_forward_integrator_core_macros.svh"

module kinematic_state_forward_integrator_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [ksfi_pkg::STEP_W-1:0]  cfg_step_ms_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic signed [31:0]           start_x_i,
  input  wire logic signed [31:0]           start_y_i,
  input  wire logic signed [31:0]           start_z_i,
  input  wire logic signed [31:0]           heading_i,
  input  wire logic signed [20:0]           speed_i,
  input  wire logic signed [20:0]           accel_i,
  input  wire logic signed [20:0]           curvature_i,
  input  wire logic [15:0]                  horizon_ms_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic signed [31:0]                end_x_o,
  output logic signed [31:0]                end_y_o,
  output logic signed [31:0]                end_z_o,
  output logic signed [31:0]                end_heading_o,
  output logic signed [20:0]                end_speed_o,
  output logic signed [20:0]                end_accel_o,
  output logic signed [20:0]                end_curvature_o,
  output logic                              bad_horizon_o
);

  // sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LOOP  = 4'd1;
  localparam logic [3:0] ST_MUL   = 4'd2;
  localparam logic [3:0] ST_DIVGO = 4'd3;
  localparam logic [3:0] ST_DIVW  = 4'd4;
  localparam logic [3:0] ST_MODGO = 4'd5;
  localparam logic [3:0] ST_MODW  = 4'd6;
  localparam logic [3:0] ST_CORD  = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  // jobs for the shared multiplier and divider
  localparam logic [2:0] J_DA  = 3'd0;  // a*dt/1000
  localparam logic [2:0] J_DAH = 3'd1;  // a*dt/2000
  localparam logic [2:0] J_VDT = 3'd2;  // v*dt
  localparam logic [2:0] J_VM  = 3'd3;  // vm*dt
  localparam logic [2:0] J_THM = 3'd4;  // midpoint heading
  localparam logic [2:0] J_X   = 3'd5;
  localparam logic [2:0] J_Y   = 3'd6;
  localparam logic [2:0] J_TH  = 3'd7;

  localparam logic signed [20:0] PI_Q16      = 21'sd205887;
  localparam logic signed [20:0] TWO_PI_Q16  = 21'sd411775;
  localparam logic signed [20:0] HALF_PI_Q16 = 21'sd102944;

  logic [3:0]                      state_q;
  logic [2:0]                      job_q;
  logic [ksfi_pkg::STEP_W-1:0]     step_ms_q, dt_q, dt0;
  logic [15:0]                     rem_hz_q;
  logic [ksfi_pkg::STEPS_W-1:0]    step_cnt_q;
  logic                            bad_q;
  logic signed [31:0]              x_q, y_q, z_q, th_q;
  logic signed [20:0]              v_q, a_q, k_q;
  logic signed [21:0]              da_q, dah_q;
  logic signed [22:0]              vm_q;
  logic signed [32:0]              vdt_q;
  logic signed [33:0]              vmdt_q, thm_q;
  logic signed [63:0]              p_q;
  logic signed [33:0]              cx_q, cy_q;
  logic signed [31:0]              cz_q;
  logic                            cneg_q, dneg_q;
  logic [3:0]                      cnt_q;

  logic                            out_valid_q, bad_out_q;
  logic signed [31:0]              ox_q, oy_q, oz_q, oth_q;
  logic signed [20:0]              ov_q, oa_q, ok_q;

  // saturation helpers
  function automatic logic signed [31:0] sat32(input logic signed [41:0] s);
    if (s > 42'sd2147483647)       return 32'sh7FFFFFFF;
    else if (s < -42'sd2147483648) return 32'sh80000000;
    else                           return s[31:0];
  endfunction

  function automatic logic signed [20:0] sat21(input logic signed [22:0] s);
    if (s > 23'sd1048575)       return 21'sh0FFFFF;
    else if (s < -23'sd1048576) return 21'sh100000;
    else                        return s[20:0];
  endfunction

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // shared multiplier operand select
  logic signed [33:0] ma, mb, cos_v, sin_v;
  logic signed [67:0] mres;
  logic signed [33:0] dt_s, k_s;

  assign cos_v = cneg_q ? -cx_q : cx_q;
  assign sin_v = cneg_q ? -cy_q : cy_q;
  assign dt_s  = {24'b0, dt_q};
  assign k_s   = {{13{k_q[20]}}, k_q};

  always_comb begin
    case (job_q)
      J_DA, J_DAH: begin ma = {{13{a_q[20]}}, a_q};   mb = dt_s;  end
      J_VDT:       begin ma = {{13{v_q[20]}}, v_q};   mb = dt_s;  end
      J_VM:        begin ma = {{11{vm_q[22]}}, vm_q}; mb = dt_s;  end
      J_THM:       begin ma = {vdt_q[32], vdt_q};     mb = k_s;   end
      J_X:         begin ma = vmdt_q;                 mb = cos_v; end
      J_Y:         begin ma = vmdt_q;                 mb = sin_v; end
      J_TH:        begin ma = vmdt_q;                 mb = k_s;   end
      default:     begin ma = '0;                     mb = '0;    end
    endcase
  end

  assign mres = ma * mb;

  // rounding offset and power-of-two part of each divisor
  logic signed [63:0] nh, shd;
  logic               dv_neg;
  logic [63:0]        dv_mag;
  logic [33:0]        thm_mag;

  always_comb begin
    case (job_q)
      J_DA:     begin nh = p_q + 64'sd500;          shd = nh >>> 3;  end
      J_DAH:    begin nh = p_q + 64'sd1000;         shd = nh >>> 4;  end
      J_THM:    begin nh = p_q + 64'sd1024000;      shd = nh >>> 14; end
      J_X, J_Y: begin nh = p_q + 64'sd536870912000; shd = nh >>> 33; end
      J_TH:     begin nh = p_q + 64'sd512000;       shd = nh >>> 13; end
      default:  begin nh = p_q;                     shd = p_q;       end
    endcase
  end

  // floor division of a negative value through its complement
  assign dv_neg  = shd[63];
  assign dv_mag  = dv_neg ? ~shd : shd;
  assign thm_mag = thm_q[33] ? -thm_q : thm_q;

  // shared divider
  ksfi_pkg::div_req_t            div_req;
  logic [ksfi_pkg::DIV_W-1:0]    div_dividend, div_quot;
  logic [ksfi_pkg::DEN_W-1:0]    div_rem;
  logic                          div_done;

  assign div_req.start   = ((state_q == ST_DIVGO) && (job_q != J_VDT) && (job_q != J_VM))
                           || (state_q == ST_MODGO);
  assign div_req.mod_sel = (state_q == ST_MODGO);
  assign div_dividend    = (state_q == ST_MODGO) ? {6'b0, thm_mag} : dv_mag[39:0];

  ksfi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dividend),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // signed quotient and the sums that use it
  logic signed [40:0] qs;
  logic signed [41:0] x_sum, y_sum, th_sum;
  logic signed [33:0] thm_sum;
  logic signed [22:0] v_sum, vm_new;

  assign qs      = dneg_q ? ~{1'b0, div_quot} : {1'b0, div_quot};
  assign x_sum   = {{10{x_q[31]}}, x_q} + {qs[40], qs};
  assign y_sum   = {{10{y_q[31]}}, y_q} + {qs[40], qs};
  assign th_sum  = {{10{th_q[31]}}, th_q} + {qs[40], qs};
  assign thm_sum = {{2{th_q[31]}}, th_q} + qs[33:0];
  assign v_sum   = {{2{v_q[20]}}, v_q} + {da_q[21], da_q};
  assign vm_new  = {{2{v_q[20]}}, v_q} + {dah_q[21], dah_q};

  // angle reduction and fold to the right half plane
  logic signed [20:0] a0, a1, a2;
  logic               fneg;
  logic signed [31:0] cz_init;

  always_comb begin
    a0 = thm_q[33] ? -$signed({2'b0, div_rem}) : $signed({2'b0, div_rem});
    if (a0 > PI_Q16)       a1 = a0 - TWO_PI_Q16;
    else if (a0 < -PI_Q16) a1 = a0 + TWO_PI_Q16;
    else                   a1 = a0;
    fneg = 1'b0;
    if (a1 > HALF_PI_Q16) begin
      a2 = a1 - PI_Q16;
      fneg = 1'b1;
    end else if (a1 < -HALF_PI_Q16) begin
      a2 = a1 + PI_Q16;
      fneg = 1'b1;
    end else begin
      a2 = a1;
    end
    cz_init = {a2[19:0], 12'b0};
  end

  // one CORDIC rotation
  logic signed [33:0] dx, dy;
  assign dx = cy_q >>> cnt_q;
  assign dy = cx_q >>> cnt_q;

  // step length for the new item
  assign dt0 = (step_ms_q == '0) ? ksfi_pkg::STEP_W'(1) : step_ms_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      job_q       <= J_DA;
      step_ms_q   <= ksfi_pkg::STEP_RESET;
      step_cnt_q  <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        step_ms_q <= cfg_step_ms_i;
      end

      if ((state_q == ST_OUT) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            step_cnt_q <= '0;
            job_q      <= J_DA;
            state_q    <= (horizon_ms_i == '0) ? ST_OUT : ST_MUL;
          end
        end
        ST_LOOP: begin
          if ((step_cnt_q == ksfi_pkg::STEPS_W'(ksfi_pkg::MAX_STEPS))
              || (rem_hz_q < {6'b0, dt_q})) begin
            state_q <= ST_OUT;
          end else begin
            step_cnt_q <= step_cnt_q + 1'b1;
            job_q      <= J_VDT;
            state_q    <= ST_MUL;
          end
        end
        ST_MUL: state_q <= ST_DIVGO;
        ST_DIVGO: begin
          case (job_q)
            J_VDT:   begin job_q <= J_VM;  state_q <= ST_MUL; end
            J_VM:    begin job_q <= J_THM; state_q <= ST_MUL; end
            default: state_q <= ST_DIVW;
          endcase
        end
        ST_DIVW: begin
          if (div_done) begin
            case (job_q)
              J_DA:    begin job_q <= J_DAH; state_q <= ST_MUL; end
              J_DAH:   state_q <= ST_LOOP;
              J_THM:   state_q <= ST_MODGO;
              J_X:     begin job_q <= J_Y;  state_q <= ST_MUL; end
              J_Y:     begin job_q <= J_TH; state_q <= ST_MUL; end
              J_TH:    state_q <= ST_LOOP;
              default: state_q <= ST_LOOP;
            endcase
          end
        end
        ST_MODGO: state_q <= ST_MODW;
        ST_MODW: begin
          if (div_done) begin
            cnt_q   <= '0;
            state_q <= ST_CORD;
          end
        end
        ST_CORD: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 4'(ksfi_pkg::CORDIC_ITERS - 1)) begin
            job_q   <= J_X;
            state_q <= ST_MUL;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          x_q      <= start_x_i;
          y_q      <= start_y_i;
          z_q      <= start_z_i;
          th_q     <= heading_i;
          v_q      <= speed_i;
          a_q      <= accel_i;
          k_q      <= curvature_i;
          rem_hz_q <= horizon_ms_i;
          bad_q    <= (horizon_ms_i == '0);
          dt_q     <= ({6'b0, dt0} > horizon_ms_i) ? horizon_ms_i[ksfi_pkg::STEP_W-1:0]
                                                   : dt0;
        end
      end
      ST_LOOP: begin
        rem_hz_q <= rem_hz_q - {6'b0, dt_q};
        vm_q     <= vm_new;
      end
      ST_MUL: p_q <= mres[63:0];
      ST_DIVGO: begin
        dneg_q <= dv_neg;
        if (job_q == J_VDT) vdt_q  <= p_q[32:0];
        if (job_q == J_VM)  vmdt_q <= p_q[33:0];
      end
      ST_DIVW: begin
        if (div_done) begin
          case (job_q)
            J_DA:    da_q  <= qs[21:0];
            J_DAH:   dah_q <= qs[21:0];
            J_THM:   thm_q <= thm_sum;
            J_X:     x_q   <= sat32(x_sum);
            J_Y:     y_q   <= sat32(y_sum);
            J_TH: begin
              th_q <= sat32(th_sum);
              v_q  <= sat21(v_sum);
            end
            default: ;
          endcase
        end
      end
      ST_MODW: begin
        if (div_done) begin
          cx_q   <= ksfi_pkg::CORDIC_GAIN_Q30;
          cy_q   <= '0;
          cz_q   <= cz_init;
          cneg_q <= fneg;
        end
      end
      ST_CORD: begin
        if (cz_q >= 0) begin
          cx_q <= cx_q - dx;
          cy_q <= cy_q + dy;
          cz_q <= cz_q - ksfi_pkg::ATAN_Q28[cnt_q];
        end else begin
          cx_q <= cx_q + dx;
          cy_q <= cy_q - dy;
          cz_q <= cz_q + ksfi_pkg::ATAN_Q28[cnt_q];
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_OUT) && (!out_valid_q || out_ready_i)) begin
      ox_q      <= x_q;
      oy_q      <= y_q;
      oz_q      <= z_q;
      oth_q     <= th_q;
      ov_q      <= v_q;
      oa_q      <= a_q;
      ok_q      <= k_q;
      bad_out_q <= bad_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign end_x_o         = ox_q;
  assign end_y_o         = oy_q;
  assign end_z_o         = oz_q;
  assign end_heading_o   = oth_q;
  assign end_speed_o     = ov_q;
  assign end_accel_o     = oa_q;
  assign end_curvature_o = ok_q;
  assign bad_horizon_o   = bad_out_q;

  // checks
  `KSFI_ASSERT_NEXT(a_zero_hz_out, in_valid_i && in_ready_o && (horizon_ms_i == '0), state_q == ST_OUT, "zero horizon did not go to output")
  `KSFI_ASSERT_NOW(a_div_done_wait, div_done, (state_q == ST_DIVW) || (state_q == ST_MODW), "divider finished outside a wait state")
  `KSFI_ASSERT_NOW(a_cord_cnt_idle, state_q != ST_CORD, cnt_q == '0, "CORDIC counter left nonzero")
  `KSFI_ASSERT_NOW(a_loop_dt_nz, state_q == ST_LOOP, dt_q != '0, "zero step length in step loop")
  `KSFI_ASSERT_NOW(a_steps_max, state_q == ST_LOOP, step_cnt_q <= ksfi_pkg::STEPS_W'(ksfi_pkg::MAX_STEPS), "step count above limit")

endmodule

`default_nettype wire

### verif/tb_kinematic_state_forward_integrator_core.sv
// Testbench for kinematic_state_forward_integrator_core: directed table, then random items.
// Depends on ksfi_pkg and the block; predicts untyped items with its own fixed-point model.
`timescale 1ns / 1ps

module tb_kinematic_state_forward_integrator_core;
  import ksfi_pkg::*;

  localparam longint PI_Q16      = 205887;
  localparam longint TWO_PI_Q16  = 411775;
  localparam longint HALF_PI_Q16 = 102944;
  localparam longint GAIN_Q30    = 652032874;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int     HOLD_CYCLES = 3000;

  typedef struct {
    logic signed [31:0] x, y, z, hd;
    logic signed [20:0] v, a, k;
    logic        [15:0] hz;
  } pose_req_t;

  typedef struct {
    logic signed [31:0] x, y, z, hd;
    logic signed [20:0] v, a, k;
    logic               bad;
  } pose_res_t;

  typedef struct {
    pose_req_t req;
    bit        typed;
    pose_res_t res;
  } stim_row_t;

  typedef struct {
    bit        typed;
    pose_res_t res;
  } typed_ent_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [STEP_W-1:0] cfg_step_ms_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] start_x_i = '0, start_y_i = '0, start_z_i = '0, heading_i = '0;
  logic signed [20:0] speed_i = '0, accel_i = '0, curvature_i = '0;
  logic [15:0] horizon_ms_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] end_x_o, end_y_o, end_z_o, end_heading_o;
  logic signed [20:0] end_speed_o, end_accel_o, end_curvature_o;
  logic bad_horizon_o;

  kinematic_state_forward_integrator_core dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_step_ms_i,
    .in_valid_i, .in_ready_o,
    .start_x_i, .start_y_i, .start_z_i, .heading_i,
    .speed_i, .accel_i, .curvature_i, .horizon_ms_i,
    .out_valid_o, .out_ready_i,
    .end_x_o, .end_y_o, .end_z_o, .end_heading_o,
    .end_speed_o, .end_accel_o, .end_curvature_o, .bad_horizon_o
  );

  always #5 clk_i = ~clk_i;

  logic [STEP_W-1:0] step_model = STEP_RESET;
  pose_res_t  pending_pose_q[$];
  typed_ent_t typed_q[$];
  int errors = 0;
  int results_seen = 0;
  int sat_items = 0;
  int zero_items = 0;
  longint cycles = 0;
  bit hold_done = 0;
  bit rx_burst = 0;

  // ---- fixed-point predictor ----
  function automatic longint sat_to(longint v, int w);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint div_round(longint n, longint d);
    longint q, m;
    m = n + d / 2;
    q = m / d;
    if ((m % d) != 0 && m < 0) q--;
    return q;
  endfunction

  function automatic void sin_cos(longint ang, output longint c, output longint s);
    longint a, x, y, z, dx, dy;
    bit neg;
    a = ang % TWO_PI_Q16;
    neg = 0;
    if (a > PI_Q16) a -= TWO_PI_Q16;
    else if (a < -PI_Q16) a += TWO_PI_Q16;
    if (a > HALF_PI_Q16) begin
      a -= PI_Q16;
      neg = 1;
    end else if (a < -HALF_PI_Q16) begin
      a += PI_Q16;
      neg = 1;
    end
    x = GAIN_Q30;
    y = 0;
    z = a * 4096;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_Q28[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_Q28[i]);
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic pose_res_t integrate_pose(pose_req_t r, logic [STEP_W-1:0] step);
    pose_res_t o;
    longint x, y, th, v, a, k, hz, dt, n, vm, thm, c, s;
    x = r.x; y = r.y; th = r.hd; v = r.v; a = r.a; k = r.k; hz = r.hz;
    o.bad = (hz == 0);
    if (hz != 0) begin
      dt = step;
      if (dt == 0) dt = 1;
      if (dt > hz) dt = hz;
      n = hz / dt;
      if (n > MAX_STEPS) n = MAX_STEPS;
      for (longint i = 0; i < n; i++) begin
        vm  = v + div_round(a * dt, 2000);
        thm = th + div_round(v * k * dt, 2000 * 1024);
        sin_cos(thm, c, s);
        x  = sat_to(x + div_round(vm * c * dt, longint'(1000) <<< 30), 32);
        y  = sat_to(y + div_round(vm * s * dt, longint'(1000) <<< 30), 32);
        th = sat_to(th + div_round(vm * k * dt, 1000 * 1024), 32);
        v  = sat_to(v + div_round(a * dt, 1000), 21);
      end
    end
    o.x = x; o.y = y; o.z = r.z; o.hd = th;
    o.v = v; o.a = r.a; o.k = r.k;
    return o;
  endfunction

  function automatic pose_res_t echo_pose(pose_req_t r);
    pose_res_t o;
    o.x = r.x; o.y = r.y; o.z = r.z; o.hd = r.hd;
    o.v = r.v; o.a = r.a; o.k = r.k; o.bad = 1'b1;
    return o;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // ---- monitor: register shadow, predictions on accept, checks on result ----
  always @(posedge clk_i) begin
    pose_req_t r;
    pose_res_t e;
    typed_ent_t t;
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (cfg_valid_i && cfg_ready_o) step_model <= cfg_step_ms_i;
      if (in_valid_i && in_ready_o) begin
        r.x = start_x_i; r.y = start_y_i; r.z = start_z_i; r.hd = heading_i;
        r.v = speed_i; r.a = accel_i; r.k = curvature_i; r.hz = horizon_ms_i;
        t = typed_q.pop_front();
        pending_pose_q.push_back(t.typed ? t.res : integrate_pose(r, step_model));
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_pose_q.size() == 0) begin
          $display("%0t ns: result with no pending item, actual x %0d", $time, end_x_o);
          errors++;
        end else begin
          e = pending_pose_q.pop_front();
          check_field("end_x", e.x, end_x_o);
          check_field("end_y", e.y, end_y_o);
          check_field("end_z", e.z, end_z_o);
          check_field("end_heading", e.hd, end_heading_o);
          check_field("end_speed", e.v, end_speed_o);
          check_field("end_accel", e.a, end_accel_o);
          check_field("end_curvature", e.k, end_curvature_o);
          check_field("bad_horizon", e.bad, bad_horizon_o);
          if (e.bad) zero_items++;
          if (e.v == 21'sh0FFFFF || e.v == -21'sh100000) sat_items++;
        end
        results_seen++;
      end
    end
  end

  // ---- timeout ----
  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, pending_pose_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---- receiver: random stalls, one long hold-off ----
  initial begin
    int gap;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      gap = rx_burst ? 0 : $urandom_range(0, 9);
      if (results_seen == 8 && !hold_done) begin
        hold_done = 1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if ($urandom_range(0, 15) == 0) rx_burst = ~rx_burst;
    end
  end

  // ---- sender helpers ----
  bit tx_burst = 0;

  task automatic offer_item(pose_req_t r, bit typed, pose_res_t res);
    int gap;
    typed_ent_t t;
    gap = tx_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    t.typed = typed;
    t.res = res;
    typed_q.push_back(t);
    in_valid_i <= 1'b1;
    start_x_i <= r.x; start_y_i <= r.y; start_z_i <= r.z; heading_i <= r.hd;
    speed_i <= r.v; accel_i <= r.a; curvature_i <= r.k; horizon_ms_i <= r.hz;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_pose_q.size() != 0 || typed_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_step(logic [STEP_W-1:0] val);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_step_ms_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic pose_req_t random_pose(logic [STEP_W-1:0] step);
    pose_req_t r;
    int sel;
    longint dt, hz;
    r.x = $urandom; r.y = $urandom; r.z = $urandom; r.hd = $urandom;
    if ($urandom_range(0, 1)) begin
      // plausible vehicle state
      r.v = $signed(21'($urandom_range(0, 61440))) - 21'sd30720;
      r.a = $signed(21'($urandom_range(0, 8192))) - 21'sd4096;
      r.k = $signed(21'($urandom_range(0, 26214))) - 21'sd13107;
      r.x = $signed(32'($urandom_range(0, 2000000))) - 32'sd1000000;
      r.y = $signed(32'($urandom_range(0, 2000000))) - 32'sd1000000;
    end else begin
      r.v = $urandom; r.a = $urandom; r.k = $urandom;
    end
    dt = (step == 0) ? 1 : step;
    sel = $urandom_range(0, 19);
    if (sel == 0) hz = 0;
    else if (sel == 1) hz = $urandom_range(32768, 65535);
    else if (sel == 2) hz = $urandom_range(1, dt);
    else begin
      hz = $urandom_range(1, dt * 12);
      if (hz > 65535) hz = 65535;
    end
    r.hz = hz;
    return r;
  endfunction

  function automatic pose_req_t mk_pose(longint x, longint y, longint z, longint hd,
                                        longint v, longint a, longint k, longint hz);
    pose_req_t r;
    r.x = x; r.y = y; r.z = z; r.hd = hd; r.v = v; r.a = a; r.k = k; r.hz = hz;
    return r;
  endfunction

  // ---- main sequence ----
  stim_row_t stim_rows[$];
  logic [STEP_W-1:0] phase_steps[6] = '{10'd1000, 10'd1, 10'd0, 10'd1023, 10'd537, 10'd50};

  initial begin
    stim_row_t row;
    pose_res_t none;
    none = '{default: '0};

    // directed rows; zero horizons come back unchanged with the flag set
    row.typed = 0; row.res = none;
    row.req = mk_pose(0, 0, 0, 0, 0, 0, 0, 0);
    row.typed = 1; row.res = echo_pose(row.req); stim_rows.push_back(row);
    row.req = mk_pose(2147483647, 2147483647, 2147483647, 2147483647,
                      1048575, 1048575, 1048575, 0);
    row.res = echo_pose(row.req); stim_rows.push_back(row);
    row.req = mk_pose(-2147483648, -2147483648, -2147483648, -2147483648,
                      -1048576, -1048576, -1048576, 0);
    row.res = echo_pose(row.req); stim_rows.push_back(row);
    row.typed = 0; row.res = none;
    // horizon shorter than one step, at one step, and just over two steps
    stim_rows.push_back('{mk_pose(1000, -1000, 5, 0, 20480, 1024, 655, 1), 0, none});
    stim_rows.push_back('{mk_pose(1000, -1000, 5, 0, 20480, 1024, 655, 49), 0, none});
    stim_rows.push_back('{mk_pose(1000, -1000, 5, 0, 20480, 1024, 655, 50), 0, none});
    stim_rows.push_back('{mk_pose(1000, -1000, 5, 0, 20480, 1024, 655, 101), 0, none});
    // step count clipped to the maximum
    stim_rows.push_back('{mk_pose(0, 0, 7, 51472, 10240, -512, 3277, 65535), 0, none});
    // speed and heading saturation
    stim_rows.push_back('{mk_pose(0, 0, 0, 2147483000, 1048575, 1048575, 1048575, 500),
                          0, none});
    stim_rows.push_back('{mk_pose(0, 0, 0, -2147483000, -1048576, -1048576, 1048575, 500),
                          0, none});
    // position saturation at both ends
    stim_rows.push_back('{mk_pose(2147483000, 0, 0, 0, 1048575, 0, 0, 300), 0, none});
    stim_rows.push_back('{mk_pose(0, -2147483000, 0, -102944, 1048575, 0, 0, 300), 0, none});
    // angle folding around +-pi/2 and +-pi, and a wrap past 2*pi
    stim_rows.push_back('{mk_pose(0, 0, 0, 102945, 30720, 0, 0, 100), 0, none});
    stim_rows.push_back('{mk_pose(0, 0, 0, -102945, 30720, 0, 0, 100), 0, none});
    stim_rows.push_back('{mk_pose(0, 0, 0, 205887, 30720, 0, 0, 100), 0, none});
    stim_rows.push_back('{mk_pose(0, 0, 0, -205888, 30720, 0, 0, 100), 0, none});
    stim_rows.push_back('{mk_pose(0, 0, 0, 1000000, -30720, 2048, -6554, 250), 0, none});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i]) offer_item(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].res);

    // random phases across register settings, reset value included
    foreach (phase_steps[p]) begin
      write_step(phase_steps[p]);
      for (int j = 0; j < 14; j++) begin
        if (j % 5 == 0) tx_burst = ($urandom_range(0, 3) == 0);
        if (p == 0 && j == 7) drain_results();
        offer_item(random_pose(step_model), 0, none);
      end
    end

    drain_results();
    repeat (200) @(posedge clk_i);
    $display("covered %0d results over %0d step settings, %0d zero horizons, %0d speed clips",
             results_seen, $size(phase_steps) + 1, zero_items, sat_items);
    if (errors == 0 && pending_pose_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_pose_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
